// ===== design/tkms_pkg.sv =====
package tkms_pkg;

  // sizing of the retained store
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;

  // field widths
  localparam int FIT_W  = 16;
  localparam int TAG_W  = 16;
  localparam int KEY_W  = FIT_W + TAG_W;
  localparam int KEEP_W = 7;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  // input operation codes
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // datapath commands
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_UP_START,
    DP_RD_PARENT,
    DP_UP_STEP,
    DP_RD_ROOT,
    DP_RD_LEFT,
    DP_RD_RIGHT,
    DP_DN_STEP,
    DP_WRITE_KEY,
    DP_EMIT_OFFER,
    DP_EMIT_POP,
    DP_RD_LAST,
    DP_LOAD_LAST
  } dp_op_t;

  // datapath status toward the controller
  typedef struct packed {
    logic is_drain;
    logic below_limit;
    logic total_zero;
    logic last_pop;
    logic at_root;
    logic up_swap;
    logic root_better;
    logic left_exists;
    logic dn_swap;
    logic out_free;
  } dp_status_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_UP_CHECK,
    ST_UP_STEP,
    ST_REPL_CHK,
    ST_DN_CHECK,
    ST_DN_RDR,
    ST_DN_STEP,
    ST_EMIT,
    ST_DR_WAIT,
    ST_DR_OUT,
    ST_DR_LAST,
    ST_DR_MOVE
  } ctrl_state_t;

endpackage

// ===== design/tkms_item_if.sv =====
interface tkms_item_if;
  import tkms_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [FIT_W-1:0] fitness;
  logic [TAG_W-1:0] tag;

  modport source (output valid, output op, output fitness, output tag, input ready);
  modport sink (input valid, input op, input fitness, input tag, output ready);
endinterface

// ===== design/tkms_result_if.sv =====
interface tkms_result_if;
  import tkms_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIT_W-1:0]   best_fitness;
  logic [TAG_W-1:0]   best_tag;
  logic               have_best;
  logic [KEEP_W-1:0]  kept_count;
  logic [FIT_W-1:0]   entry_fitness;
  logic [TAG_W-1:0]   entry_tag;
  logic               entry_valid;
  logic               last;

  modport source (
    output valid, output best_fitness, output best_tag, output have_best,
    output kept_count, output entry_fitness, output entry_tag,
    output entry_valid, output last, input ready
  );
  modport sink (
    input valid, input best_fitness, input best_tag, input have_best,
    input kept_count, input entry_fitness, input entry_tag,
    input entry_valid, input last, output ready
  );
endinterface

// ===== design/tkms_cfg_if.sv =====
interface tkms_cfg_if;
  import tkms_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEEP_W-1:0] keep_count;

  modport source (output valid, output keep_count, input ready);
  modport sink (input valid, input keep_count, output ready);
endinterface

// ===== design/tkms_ram.sv =====
module tkms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tkms_datapath.sv =====
module tkms_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  tkms_pkg::dp_op_t             cmd,
  output tkms_pkg::dp_status_t         status,
  input  logic                         item_op,
  input  logic [tkms_pkg::FIT_W-1:0]   item_fitness,
  input  logic [tkms_pkg::TAG_W-1:0]   item_tag,
  input  logic                         cfg_valid,
  input  logic [tkms_pkg::KEEP_W-1:0]  cfg_keep_count,
  tkms_result_if.source                result
);
  import tkms_pkg::*;

  // control and persistent state
  logic [COUNT_W-1:0] total;
  logic [KEEP_W-1:0]  keep_count;
  logic [FIT_W-1:0]   best_fit;
  logic [TAG_W-1:0]   best_tag;
  logic               have_best;
  logic               out_valid;

  // working registers
  logic               op_r;
  logic [KEY_W-1:0]   key;
  logic [ADDR_W-1:0]  idx;
  logic [KEY_W-1:0]   left_q;

  // output register
  logic [FIT_W-1:0]   out_best_fit;
  logic [TAG_W-1:0]   out_best_tag;
  logic               out_have_best;
  logic [KEEP_W-1:0]  out_kept;
  logic [FIT_W-1:0]   out_entry_fit;
  logic [TAG_W-1:0]   out_entry_tag;
  logic               out_entry_valid;
  logic               out_last;

  // store port
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [KEY_W-1:0]   wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [KEY_W-1:0]   rdata;

  // derived values
  logic [COUNT_W-1:0] lim;
  logic [ADDR_W-1:0]  parent_idx;
  logic [CHILD_W-1:0] left_idx;
  logic [CHILD_W-1:0] right_idx;
  logic               right_ok;
  logic [KEY_W-1:0]   child_key;
  logic [ADDR_W-1:0]  child_idx;
  logic [COUNT_W-1:0] total_dec;

  tkms_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // effective retention limit, clamped to 1..CAPACITY
  always_comb begin
    if (keep_count == '0) begin
      lim = COUNT_W'(1);
    end else if (keep_count > KEEP_W'(CAPACITY)) begin
      lim = COUNT_W'(CAPACITY);
    end else begin
      lim = COUNT_W'(keep_count);
    end
  end

  // heap index arithmetic
  assign parent_idx = (idx - ADDR_W'(1)) >> 1;
  assign left_idx   = {1'b0, idx, 1'b1};
  assign right_idx  = left_idx + CHILD_W'(1);
  assign right_ok   = (right_idx < CHILD_W'(total)) && (rdata > left_q);
  assign child_key  = right_ok ? rdata : left_q;
  assign child_idx  = right_ok ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
  assign total_dec  = total - COUNT_W'(1);

  // status toward the controller
  always_comb begin
    status.is_drain    = (op_r == OP_DRAIN);
    status.below_limit = (total < lim);
    status.total_zero  = (total == '0);
    status.last_pop    = (total == COUNT_W'(1));
    status.at_root     = (idx == '0);
    status.up_swap     = (key > rdata);
    status.root_better = (key[KEY_W-1:TAG_W] < rdata[KEY_W-1:TAG_W]);
    status.left_exists = (left_idx < CHILD_W'(total));
    status.dn_swap     = (child_key > key);
    status.out_free    = !out_valid || result.ready;
  end

  // store addressing per command
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = key;
    raddr = '0;
    unique case (cmd)
      DP_RD_PARENT: raddr = parent_idx;
      DP_RD_LEFT:   raddr = left_idx[ADDR_W-1:0];
      DP_RD_RIGHT:  raddr = right_idx[ADDR_W-1:0];
      DP_RD_LAST:   raddr = total[ADDR_W-1:0];
      DP_WRITE_KEY: we = 1'b1;
      DP_UP_STEP: begin
        we    = 1'b1;
        wdata = status.up_swap ? rdata : key;
      end
      DP_DN_STEP: begin
        we    = 1'b1;
        wdata = status.dn_swap ? child_key : key;
      end
      default: ;
    endcase
  end

  // control and persistent registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      keep_count <= KEEP_RESET;
      best_fit   <= '0;
      best_tag   <= '0;
      have_best  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        keep_count <= cfg_keep_count;
      end
      // result leaves on transfer, a new one may load in the same cycle
      if (cmd == DP_EMIT_OFFER || cmd == DP_EMIT_POP) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        DP_LOAD: begin
          if (item_op == OP_OFFER && (!have_best || item_fitness < best_fit)) begin
            best_fit  <= item_fitness;
            best_tag  <= item_tag;
            have_best <= 1'b1;
          end
        end
        DP_UP_START: total <= total + COUNT_W'(1);
        DP_EMIT_POP: total <= total_dec;
        default: ;
      endcase
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      DP_LOAD: begin
        op_r <= item_op;
        key  <= {item_fitness, item_tag};
      end
      DP_UP_START: idx <= total[ADDR_W-1:0];
      DP_UP_STEP: begin
        if (status.up_swap) begin
          idx <= parent_idx;
        end
      end
      DP_RD_ROOT:   idx <= '0;
      DP_RD_RIGHT:  left_q <= rdata;
      DP_DN_STEP: begin
        if (status.dn_swap) begin
          idx <= child_idx;
        end
      end
      DP_LOAD_LAST: key <= rdata;
      DP_EMIT_OFFER: begin
        out_best_fit    <= best_fit;
        out_best_tag    <= best_tag;
        out_have_best   <= have_best;
        out_kept        <= KEEP_W'(total);
        out_entry_fit   <= '0;
        out_entry_tag   <= '0;
        out_entry_valid <= 1'b0;
        out_last        <= 1'b1;
      end
      DP_EMIT_POP: begin
        out_best_fit    <= best_fit;
        out_best_tag    <= best_tag;
        out_have_best   <= have_best;
        out_kept        <= KEEP_W'(total_dec);
        out_entry_fit   <= rdata[KEY_W-1:TAG_W];
        out_entry_tag   <= rdata[TAG_W-1:0];
        out_entry_valid <= 1'b1;
        out_last        <= (total_dec == '0);
      end
      default: ;
    endcase
  end

  assign result.valid         = out_valid;
  assign result.best_fitness  = out_best_fit;
  assign result.best_tag      = out_best_tag;
  assign result.have_best     = out_have_best;
  assign result.kept_count    = out_kept;
  assign result.entry_fitness = out_entry_fit;
  assign result.entry_tag     = out_entry_tag;
  assign result.entry_valid   = out_entry_valid;
  assign result.last          = out_last;

endmodule

// ===== design/tkms_ctrl.sv =====
module tkms_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  tkms_pkg::dp_status_t  status,
  output tkms_pkg::dp_op_t      cmd
);
  import tkms_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = DP_NONE;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd        = DP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.is_drain) begin
          state_next = status.total_zero ? ST_EMIT : ST_DR_WAIT;
        end else if (status.below_limit) begin
          cmd        = DP_UP_START;
          state_next = ST_UP_CHECK;
        end else begin
          cmd        = DP_RD_ROOT;
          state_next = ST_REPL_CHK;
        end
      end
      // sift up toward the root
      ST_UP_CHECK: begin
        if (status.at_root) begin
          cmd        = DP_WRITE_KEY;
          state_next = ST_EMIT;
        end else begin
          cmd        = DP_RD_PARENT;
          state_next = ST_UP_STEP;
        end
      end
      ST_UP_STEP: begin
        cmd        = DP_UP_STEP;
        state_next = status.up_swap ? ST_UP_CHECK : ST_EMIT;
      end
      // full store: replace the worst only on strictly lower fitness
      ST_REPL_CHK: begin
        state_next = status.root_better ? ST_DN_CHECK : ST_EMIT;
      end
      // sift down from the current slot
      ST_DN_CHECK: begin
        if (status.left_exists) begin
          cmd        = DP_RD_LEFT;
          state_next = ST_DN_RDR;
        end else begin
          cmd        = DP_WRITE_KEY;
          state_next = status.is_drain ? ST_DR_WAIT : ST_EMIT;
        end
      end
      ST_DN_RDR: begin
        cmd        = DP_RD_RIGHT;
        state_next = ST_DN_STEP;
      end
      ST_DN_STEP: begin
        cmd = DP_DN_STEP;
        if (status.dn_swap) begin
          state_next = ST_DN_CHECK;
        end else begin
          state_next = status.is_drain ? ST_DR_WAIT : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd        = DP_EMIT_OFFER;
          state_next = ST_IDLE;
        end
      end
      // drain: pop the root once the output register is free
      ST_DR_WAIT: begin
        if (status.out_free) begin
          cmd        = DP_RD_ROOT;
          state_next = ST_DR_OUT;
        end
      end
      ST_DR_OUT: begin
        cmd        = DP_EMIT_POP;
        state_next = status.last_pop ? ST_IDLE : ST_DR_LAST;
      end
      ST_DR_LAST: begin
        cmd        = DP_RD_LAST;
        state_next = ST_DR_MOVE;
      end
      ST_DR_MOVE: begin
        cmd        = DP_LOAD_LAST;
        state_next = ST_DN_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== design/top_k_min_fitness_selector.sv =====
// Offer: the result is loaded once any sift-up (insert) or sift-down (replace) is done.
// Drain: each entry is read from the root once the output register is free, then loaded;
//   after a pop the last entry is moved to the root and sifted down; an empty drain
//   loads a single result.
// The next item is taken in the cycle after the last result loads, while that result waits.
// Synchronous active-high reset: store empty, no best, limit 16.
module top_k_min_fitness_selector (
  input  logic          clk,
  input  logic          rst,
  tkms_item_if.sink     item,
  tkms_result_if.source result,
  tkms_cfg_if.sink      cfg
);
  import tkms_pkg::*;

  dp_op_t     cmd;
  dp_status_t status;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  tkms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  tkms_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item_op        (item.op),
    .item_fitness   (item.fitness),
    .item_tag       (item.tag),
    .cfg_valid      (cfg.valid),
    .cfg_keep_count (cfg.keep_count),
    .result         (result)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tkms_pkg::*;

  // one expected transfer on the result channel
  typedef struct packed {
    logic [FIT_W-1:0]  best_fitness;
    logic [TAG_W-1:0]  best_tag;
    logic              have_best;
    logic [KEEP_W-1:0] kept_count;
    logic [FIT_W-1:0]  entry_fitness;
    logic [TAG_W-1:0]  entry_tag;
    logic              entry_valid;
    logic              last;
  } sel_result_t;

  logic clk;
  logic rst;

  tkms_item_if   item_bus ();
  tkms_result_if result_bus ();
  tkms_cfg_if    cfg_bus ();

  top_k_min_fitness_selector uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // predicted selector state: kept keys ascending, worst at the back
  logic [KEY_W-1:0]  kept_keys[$];
  logic [FIT_W-1:0]  best_fit_m;
  logic [TAG_W-1:0]  best_tag_m;
  logic              best_seen_m;
  logic [KEEP_W-1:0] keep_count_m;

  sel_result_t pending_results[$];

  int fail_count;
  int src_idle_pct;
  int snk_idle_pct;
  int stall_cycles_req;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // number of entries the selector may retain under the current register
  function automatic int retain_limit();
    if (keep_count_m == '0) return 1;
    if (keep_count_m > CAPACITY) return CAPACITY;
    return int'(keep_count_m);
  endfunction

  // sorted insert, equal keys go after the existing ones
  task automatic insert_key(input logic [KEY_W-1:0] key);
    int pos;
    kept_keys.push_back(key);
    pos = kept_keys.size() - 1;
    while (pos > 0 && kept_keys[pos-1] > key) begin
      kept_keys[pos] = kept_keys[pos-1];
      pos--;
    end
    kept_keys[pos] = key;
  endtask

  function automatic sel_result_t status_snapshot();
    sel_result_t r;
    r = '0;
    r.best_fitness = best_fit_m;
    r.best_tag     = best_tag_m;
    r.have_best    = best_seen_m;
    r.kept_count   = KEEP_W'(kept_keys.size());
    return r;
  endfunction

  // work out the results of one accepted item and queue them
  task automatic predict_selection(input logic op, input logic [FIT_W-1:0] fit,
                                   input logic [TAG_W-1:0] tag);
    sel_result_t      r;
    logic [KEY_W-1:0] worst;
    logic [KEY_W-1:0] popped;
    if (op == OP_OFFER) begin
      if (!best_seen_m || fit < best_fit_m) begin
        best_fit_m  = fit;
        best_tag_m  = tag;
        best_seen_m = 1'b1;
      end
      if (kept_keys.size() < retain_limit()) begin
        insert_key({fit, tag});
      end else if (kept_keys.size() > 0) begin
        worst = kept_keys[kept_keys.size()-1];
        if (fit < worst[KEY_W-1:TAG_W]) begin
          void'(kept_keys.pop_back());
          insert_key({fit, tag});
        end
      end
      r = status_snapshot();
      r.last = 1'b1;
      pending_results.push_back(r);
    end else if (kept_keys.size() == 0) begin
      r = status_snapshot();
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      while (kept_keys.size() > 0) begin
        popped = kept_keys.pop_back();
        r = status_snapshot();
        r.entry_fitness = popped[KEY_W-1:TAG_W];
        r.entry_tag     = popped[TAG_W-1:0];
        r.entry_valid   = 1'b1;
        r.last          = (kept_keys.size() == 0);
        pending_results.push_back(r);
      end
    end
  endtask

  // one item transfer, with random idle cycles ahead of it
  task automatic send_item(input logic op, input logic [FIT_W-1:0] fit,
                           input logic [TAG_W-1:0] tag);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.op      <= op;
    item_bus.fitness <= fit;
    item_bus.tag     <= tag;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    predict_selection(op, fit, tag);
  endtask

  // sender pause until every expected result has been seen
  task automatic wait_results_done();
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_keep_count(input logic [KEEP_W-1:0] value);
    wait_results_done();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.keep_count <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    keep_count_m = value;
  endtask

  // result receiver: random stalls, plus long hold-offs on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles_req > 0) begin
        stall_left = stall_cycles_req;
        stall_cycles_req = 0;
      end
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 40)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    sel_result_t want;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("best_fitness", 32'(want.best_fitness),
                    32'(result_bus.best_fitness));
        check_field("best_tag", 32'(want.best_tag), 32'(result_bus.best_tag));
        check_field("have_best", 32'(want.have_best), 32'(result_bus.have_best));
        check_field("kept_count", 32'(want.kept_count), 32'(result_bus.kept_count));
        check_field("entry_fitness", 32'(want.entry_fitness),
                    32'(result_bus.entry_fitness));
        check_field("entry_tag", 32'(want.entry_tag), 32'(result_bus.entry_tag));
        check_field("entry_valid", 32'(want.entry_valid),
                    32'(result_bus.entry_valid));
        check_field("last", 32'(want.last), 32'(result_bus.last));
      end
    end
  end

  // empty drain before any offer, extremes of the fields, ties with the best
  task automatic test_empty_and_best();
    send_item(OP_DRAIN, FIT_W'($urandom), TAG_W'($urandom));
    send_item(OP_OFFER, 16'h8000, 16'h1234);
    send_item(OP_OFFER, 16'h8000, 16'h9999);
    send_item(OP_OFFER, 16'hFFFF, 16'hFFFF);
    send_item(OP_OFFER, 16'h0000, 16'h0000);
    send_item(OP_OFFER, 16'h0000, 16'hFFFF);
    send_item(OP_DRAIN, 16'hFFFF, 16'hFFFF);
    send_item(OP_DRAIN, 16'h0000, 16'h0000);
  endtask

  // zero limit, ties with the worst entry, limit lowered below contents
  task automatic test_limit_edges();
    write_keep_count('0);
    send_item(OP_OFFER, 16'd100, 16'd2);
    send_item(OP_OFFER, 16'd100, 16'd1);
    send_item(OP_OFFER, 16'd200, 16'd3);
    send_item(OP_OFFER, 16'd50, 16'd4);
    send_item(OP_DRAIN, 16'd0, 16'd0);
    write_keep_count(KEEP_W'(3));
    send_item(OP_OFFER, 16'd10, 16'd10);
    send_item(OP_OFFER, 16'd20, 16'd20);
    send_item(OP_OFFER, 16'd30, 16'd30);
    send_item(OP_OFFER, 16'd30, 16'd0);
    send_item(OP_OFFER, 16'd5, 16'd5);
    write_keep_count(KEEP_W'(1));
    send_item(OP_OFFER, 16'd7, 16'd7);
    send_item(OP_OFFER, 16'd15, 16'd15);
    send_item(OP_DRAIN, 16'd0, 16'd0);
  endtask

  // long receiver hold-off so the selector backs up into the item channel
  task automatic test_result_backpressure();
    int saved_pct;
    saved_pct = src_idle_pct;
    write_keep_count(KEEP_W'(8));
    src_idle_pct = 0;
    stall_cycles_req = 400;
    repeat (20) send_item(OP_OFFER, FIT_W'($urandom), TAG_W'($urandom));
    send_item(OP_DRAIN, 16'd0, 16'd0);
    wait_results_done();
    src_idle_pct = saved_pct;
  endtask

  // runs of offers closed by drains, under a fresh limit each round
  task automatic run_random_phase(input int src_pct, input int snk_pct, input int n_items);
    int               sent;
    int               lim;
    int               run_len;
    int               fit_mode;
    int               tag_mode;
    logic [FIT_W-1:0] fit;
    logic [TAG_W-1:0] tag;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0:       write_keep_count(KEEP_W'(CAPACITY));
        1:       write_keep_count(KEEP_W'($urandom_range(CAPACITY + 1, 127)));
        2:       write_keep_count('0);
        default: write_keep_count(KEEP_W'($urandom_range(1, 12)));
      endcase
      repeat ($urandom_range(1, 3)) begin
        lim      = retain_limit();
        run_len  = $urandom_range(1, lim + lim / 2 + 2);
        fit_mode = $urandom_range(0, 3);
        tag_mode = $urandom_range(0, 3);
        repeat (run_len) begin
          case (fit_mode)
            // narrow range, many ties
            0: fit = FIT_W'($urandom_range(0, 7));
            // both ends of the range
            1: fit = $urandom_range(0, 1) ? FIT_W'($urandom_range(65528, 65535))
                                          : FIT_W'($urandom_range(0, 3));
            default: fit = FIT_W'($urandom);
          endcase
          tag = (tag_mode == 0) ? TAG_W'($urandom_range(0, 3)) : TAG_W'($urandom);
          send_item(OP_OFFER, fit, tag);
          sent++;
        end
        // usually close the run, otherwise contents carry into the next limit
        if ($urandom_range(0, 9) < 7) begin
          send_item(OP_DRAIN, FIT_W'($urandom), TAG_W'($urandom));
          sent++;
        end
        // stray drain, often of an empty store
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_DRAIN, FIT_W'($urandom), TAG_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  // watchdog
  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // test sequence
  initial begin
    fail_count       = 0;
    stall_cycles_req = 0;
    src_idle_pct     = 32;
    snk_idle_pct     = 81;
    best_fit_m       = '0;
    best_tag_m       = '0;
    best_seen_m      = 1'b0;
    keep_count_m     = KEEP_RESET;
    rst                <= 1'b1;
    item_bus.valid     <= 1'b0;
    item_bus.op        <= OP_OFFER;
    item_bus.fitness   <= '0;
    item_bus.tag       <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.keep_count <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_best();
    test_limit_edges();
    run_random_phase(32, 81, 130);
    test_result_backpressure();
    run_random_phase(81, 32, 120);
    run_random_phase(0, 0, 130);

    wait_results_done();
    repeat (64) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
